// ===== design/tna_pkg.sv =====
package tna_pkg;

	localparam int NORM_BITS = 16;
	localparam int AREA_BITS = 33;
	localparam int Q_BITS = 16;
	localparam int RATIO_SHIFT = 30;

	localparam logic [AREA_BITS-1:0] AREA_MAX = 33'h1_FFFF_FFFF;
	localparam logic signed [NORM_BITS-1:0] NORM_MAX = 16'sh7FFF;

endpackage

// ===== design/triangle_normal_and_area_top.sv =====
// Triangle unit normal and area, fully pipelined.
//
// The input channel (in_valid, in_stall) carries the three corners of a
// triangle; the output channel (out_valid, out_stall) carries the unit
// normal in Q1.15, the area as an integer and the degenerate flag.
// Each transaction on the input yields exactly one transaction on the output,
// in order.
// A new triangle can be accepted in every cycle in which in_stall is low.
// The pipeline depth is set by the square root, which resolves one root
// bit per stage, while the normal quotients resolve one bit per stage
// alongside it in the first Q_BITS stages.
// When the receiver stalls a valid result, the whole pipeline holds and
// in_stall is raised, so nothing is lost or repeated.
// Reset clears all valid bits; the block accepts input right after reset.
// A triangle whose cross product is zero gives a zero normal, zero area
// and degenerate set.
module triangle_normal_and_area_top #(
	parameter int COORD_BITS = 16
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_stall,
	input  logic signed [COORD_BITS-1:0] a_x,
	input  logic signed [COORD_BITS-1:0] a_y,
	input  logic signed [COORD_BITS-1:0] a_z,
	input  logic signed [COORD_BITS-1:0] b_x,
	input  logic signed [COORD_BITS-1:0] b_y,
	input  logic signed [COORD_BITS-1:0] b_z,
	input  logic signed [COORD_BITS-1:0] c_x,
	input  logic signed [COORD_BITS-1:0] c_y,
	input  logic signed [COORD_BITS-1:0] c_z,
	output logic out_valid,
	input  logic out_stall,
	output logic signed [tna_pkg::NORM_BITS-1:0] normal_x,
	output logic signed [tna_pkg::NORM_BITS-1:0] normal_y,
	output logic signed [tna_pkg::NORM_BITS-1:0] normal_z,
	output logic [tna_pkg::AREA_BITS-1:0] area,
	output logic degenerate
);
	import tna_pkg::*;

	localparam int NW = 2 * COORD_BITS + 3;
	localparam int QW = 2 * NW;
	localparam int RW = NW + 1;
	localparam int SW = 2 * RW;
	localparam int CW = (RW > AREA_BITS + 1) ? RW : AREA_BITS + 1;

	logic en;
	logic cr_valid, sqr_valid, it_valid;
	logic signed [NW-1:0] nx, ny, nz;
	logic [SW-1:0] s;
	logic [QW-1:0] sq0, sq1, sq2;
	logic [2:0] neg, it_neg;
	logic deg, it_deg;
	logic [RW-1:0] root;
	logic [Q_BITS-1:0] q [3];
	logic [CW-1:0] area_w;
	logic signed [NORM_BITS-1:0] norm_w [3];
	logic valid_q;
	logic signed [NORM_BITS-1:0] norm_q [3];
	logic [AREA_BITS-1:0] area_q;
	logic deg_q;

	assign en = !(valid_q && out_stall);
	assign in_stall = valid_q && out_stall;

	tna_cross #(.COORD_BITS(COORD_BITS)) u_cross (
		.clk(clk), .arst_n(arst_n), .en(en), .in_valid(in_valid),
		.a_x(a_x), .a_y(a_y), .a_z(a_z),
		.b_x(b_x), .b_y(b_y), .b_z(b_z),
		.c_x(c_x), .c_y(c_y), .c_z(c_z),
		.out_valid(cr_valid), .nx(nx), .ny(ny), .nz(nz)
	);

	tna_square #(.COORD_BITS(COORD_BITS)) u_square (
		.clk(clk), .arst_n(arst_n), .en(en), .in_valid(cr_valid),
		.nx(nx), .ny(ny), .nz(nz),
		.out_valid(sqr_valid), .s(s), .sq0(sq0), .sq1(sq1), .sq2(sq2),
		.neg(neg), .deg(deg)
	);

	tna_iter #(.COORD_BITS(COORD_BITS)) u_iter (
		.clk(clk), .arst_n(arst_n), .en(en), .in_valid(sqr_valid),
		.s(s), .sq0(sq0), .sq1(sq1), .sq2(sq2), .neg(neg), .deg(deg),
		.out_valid(it_valid), .root(root), .q0(q[0]), .q1(q[1]), .q2(q[2]),
		.neg_out(it_neg), .deg_out(it_deg)
	);

	always_comb begin
		area_w = CW'(root >> 1);
		for (int c = 0; c < 3; c++) begin
			if (it_deg) begin
				norm_w[c] = '0;
			end else if (it_neg[c]) begin
				norm_w[c] = NORM_BITS'(-q[c]);
			end else if (q[c] > Q_BITS'(NORM_MAX)) begin
				norm_w[c] = NORM_MAX;
			end else begin
				norm_w[c] = NORM_BITS'(q[c]);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= it_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			norm_q[0] <= norm_w[0];
			norm_q[1] <= norm_w[1];
			norm_q[2] <= norm_w[2];
			area_q <= (area_w > CW'(AREA_MAX)) ? AREA_MAX : area_w[AREA_BITS-1:0];
			deg_q <= it_deg;
		end
	end

	assign out_valid = valid_q;
	assign normal_x = norm_q[0];
	assign normal_y = norm_q[1];
	assign normal_z = norm_q[2];
	assign area = area_q;
	assign degenerate = deg_q;

endmodule

// ===== design/tna_cross.sv =====
module tna_cross #(
	parameter int COORD_BITS = 16
) (
	input  logic clk,
	input  logic arst_n,
	input  logic en,
	input  logic in_valid,
	input  logic signed [COORD_BITS-1:0] a_x,
	input  logic signed [COORD_BITS-1:0] a_y,
	input  logic signed [COORD_BITS-1:0] a_z,
	input  logic signed [COORD_BITS-1:0] b_x,
	input  logic signed [COORD_BITS-1:0] b_y,
	input  logic signed [COORD_BITS-1:0] b_z,
	input  logic signed [COORD_BITS-1:0] c_x,
	input  logic signed [COORD_BITS-1:0] c_y,
	input  logic signed [COORD_BITS-1:0] c_z,
	output logic out_valid,
	output logic signed [2*COORD_BITS+2:0] nx,
	output logic signed [2*COORD_BITS+2:0] ny,
	output logic signed [2*COORD_BITS+2:0] nz
);
	localparam int DW = COORD_BITS + 1;
	localparam int PW = 2 * DW;
	localparam int NW = PW + 1;

	logic v_s1, v_s2, v_s3;
	logic signed [DW-1:0] ux_s1, uy_s1, uz_s1, vx_s1, vy_s1, vz_s1;
	logic signed [PW-1:0] pxa_s2, pxb_s2, pya_s2, pyb_s2, pza_s2, pzb_s2;
	logic signed [NW-1:0] nx_s3, ny_s3, nz_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ux_s1 <= DW'(b_x) - DW'(a_x);
			uy_s1 <= DW'(b_y) - DW'(a_y);
			uz_s1 <= DW'(b_z) - DW'(a_z);
			vx_s1 <= DW'(c_x) - DW'(a_x);
			vy_s1 <= DW'(c_y) - DW'(a_y);
			vz_s1 <= DW'(c_z) - DW'(a_z);
			pxa_s2 <= uy_s1 * vz_s1;
			pxb_s2 <= vy_s1 * uz_s1;
			pya_s2 <= vx_s1 * uz_s1;
			pyb_s2 <= ux_s1 * vz_s1;
			pza_s2 <= ux_s1 * vy_s1;
			pzb_s2 <= vx_s1 * uy_s1;
			nx_s3 <= NW'(pxa_s2) - NW'(pxb_s2);
			ny_s3 <= NW'(pya_s2) - NW'(pyb_s2);
			nz_s3 <= NW'(pza_s2) - NW'(pzb_s2);
		end
	end

	assign out_valid = v_s3;
	assign nx = nx_s3;
	assign ny = ny_s3;
	assign nz = nz_s3;

endmodule

// ===== design/tna_square.sv =====
module tna_square #(
	parameter int COORD_BITS = 16
) (
	input  logic clk,
	input  logic arst_n,
	input  logic en,
	input  logic in_valid,
	input  logic signed [2*COORD_BITS+2:0] nx,
	input  logic signed [2*COORD_BITS+2:0] ny,
	input  logic signed [2*COORD_BITS+2:0] nz,
	output logic out_valid,
	output logic [4*COORD_BITS+7:0] s,
	output logic [4*COORD_BITS+5:0] sq0,
	output logic [4*COORD_BITS+5:0] sq1,
	output logic [4*COORD_BITS+5:0] sq2,
	output logic [2:0] neg,
	output logic deg
);
	localparam int MW = 2 * COORD_BITS + 3;
	localparam int K = (MW + 1) / 2;
	localparam int H = MW - K;
	localparam int QW = 2 * MW;
	localparam int SW = 2 * MW + 2;

	logic v_s4, v_s5, v_s6, v_s7;
	logic signed [MW-1:0] n_in [3];
	logic [MW-1:0] mag_s4 [3];
	logic [2*H-1:0] hh_s5 [3];
	logic [H+K-1:0] hl_s5 [3];
	logic [2*K-1:0] ll_s5 [3];
	logic [QW-1:0] sq_s6 [3];
	logic [QW-1:0] sq_s7 [3];
	logic [2:0] neg_s4, neg_s5, neg_s6, neg_s7;
	logic [SW-1:0] s_s7;
	logic deg_s7;

	assign n_in[0] = nx;
	assign n_in[1] = ny;
	assign n_in[2] = nz;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
		end else if (en) begin
			v_s4 <= in_valid;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
		end
	end

	for (genvar c = 0; c < 3; c++) begin : g_comp
		always_ff @(posedge clk) begin
			if (en) begin
				mag_s4[c] <= n_in[c][MW-1] ? MW'(-n_in[c]) : MW'(n_in[c]);
				hh_s5[c] <= mag_s4[c][MW-1:K] * mag_s4[c][MW-1:K];
				hl_s5[c] <= mag_s4[c][MW-1:K] * mag_s4[c][K-1:0];
				ll_s5[c] <= mag_s4[c][K-1:0] * mag_s4[c][K-1:0];
				sq_s6[c] <= (QW'(hh_s5[c]) << (2 * K)) + (QW'(hl_s5[c]) << (K + 1))
					+ QW'(ll_s5[c]);
				sq_s7[c] <= sq_s6[c];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			neg_s4 <= {n_in[2][MW-1], n_in[1][MW-1], n_in[0][MW-1]};
			neg_s5 <= neg_s4;
			neg_s6 <= neg_s5;
			neg_s7 <= neg_s6;
			s_s7 <= SW'(sq_s6[0]) + SW'(sq_s6[1]) + SW'(sq_s6[2]);
			deg_s7 <= (sq_s6[0] == '0) && (sq_s6[1] == '0) && (sq_s6[2] == '0);
		end
	end

	assign out_valid = v_s7;
	assign s = s_s7;
	assign sq0 = sq_s7[0];
	assign sq1 = sq_s7[1];
	assign sq2 = sq_s7[2];
	assign neg = neg_s7;
	assign deg = deg_s7;

endmodule

// ===== design/tna_iter.sv =====
module tna_iter #(
	parameter int COORD_BITS = 16
) (
	input  logic clk,
	input  logic arst_n,
	input  logic en,
	input  logic in_valid,
	input  logic [4*COORD_BITS+7:0] s,
	input  logic [4*COORD_BITS+5:0] sq0,
	input  logic [4*COORD_BITS+5:0] sq1,
	input  logic [4*COORD_BITS+5:0] sq2,
	input  logic [2:0] neg,
	input  logic deg,
	output logic out_valid,
	output logic [2*COORD_BITS+3:0] root,
	output logic [tna_pkg::Q_BITS-1:0] q0,
	output logic [tna_pkg::Q_BITS-1:0] q1,
	output logic [tna_pkg::Q_BITS-1:0] q2,
	output logic [2:0] neg_out,
	output logic deg_out
);
	import tna_pkg::*;

	localparam int MW = 2 * COORD_BITS + 3;
	localparam int QW = 2 * MW;
	localparam int RW = MW + 1;
	localparam int SW = 2 * RW;
	localparam int WW = SW + 34;

	logic v_s [RW+1];
	logic [RW+2:0] rem_s [RW+1];
	logic [RW-1:0] root_s [RW+1];
	logic [SW-1:0] s_s [RW+1];
	logic [QW-1:0] sq_s [RW+1][3];
	logic [WW-1:0] acc_s [RW+1][3];
	logic [WW-1:0] p_s [RW+1][3];
	logic [Q_BITS-1:0] q_s [RW+1][3];
	logic [2:0] neg_s [RW+1];
	logic deg_s [RW+1];

	assign v_s[0] = in_valid;
	assign rem_s[0] = '0;
	assign root_s[0] = '0;
	assign s_s[0] = s;
	assign sq_s[0][0] = sq0;
	assign sq_s[0][1] = sq1;
	assign sq_s[0][2] = sq2;
	assign neg_s[0] = neg;
	assign deg_s[0] = deg;

	for (genvar c = 0; c < 3; c++) begin : g_init
		assign acc_s[0][c] = '0;
		assign p_s[0][c] = '0;
		assign q_s[0][c] = '0;
	end

	for (genvar k = 0; k < RW; k++) begin : g_stage
		localparam int I = RW - 1 - k;
		logic [RW+2:0] rem_sh;
		logic [RW+2:0] trial;
		logic ge;

		always_comb begin
			rem_sh = {rem_s[k][RW:0], s_s[k][2*I+1 -: 2]};
			trial = (RW+3)'({root_s[k], 2'b01});
			ge = rem_sh >= trial;
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k+1] <= 1'b0;
			end else if (en) begin
				v_s[k+1] <= v_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k+1] <= ge ? rem_sh - trial : rem_sh;
				root_s[k+1] <= {root_s[k][RW-2:0], ge};
				s_s[k+1] <= s_s[k];
				neg_s[k+1] <= neg_s[k];
				deg_s[k+1] <= deg_s[k];
			end
		end

		for (genvar c = 0; c < 3; c++) begin : g_comp
			if (k < Q_BITS) begin : g_bit
				localparam int B = Q_BITS - 1 - k;
				logic [WW-1:0] cand;
				logic [WW-1:0] lim;
				logic take;

				always_comb begin
					cand = acc_s[k][c] + (p_s[k][c] << (B + 1)) + (WW'(s_s[k]) << (2 * B));
					lim = WW'(sq_s[k][c]) << RATIO_SHIFT;
					take = cand <= lim;
				end

				always_ff @(posedge clk) begin
					if (en) begin
						acc_s[k+1][c] <= take ? cand : acc_s[k][c];
						p_s[k+1][c] <= take ? p_s[k][c] + (WW'(s_s[k]) << B) : p_s[k][c];
						q_s[k+1][c] <= q_s[k][c] | (Q_BITS'(take) << B);
						sq_s[k+1][c] <= sq_s[k][c];
					end
				end
			end else begin : g_pass
				always_ff @(posedge clk) begin
					if (en) begin
						acc_s[k+1][c] <= acc_s[k][c];
						p_s[k+1][c] <= p_s[k][c];
						q_s[k+1][c] <= q_s[k][c];
						sq_s[k+1][c] <= sq_s[k][c];
					end
				end
			end
		end
	end

	assign out_valid = v_s[RW];
	assign root = root_s[RW];
	assign q0 = q_s[RW][0];
	assign q1 = q_s[RW][1];
	assign q2 = q_s[RW][2];
	assign neg_out = neg_s[RW];
	assign deg_out = deg_s[RW];

endmodule

// ===== design/tna_checker.sv =====
module tna_checker (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_stall,
	input logic out_valid,
	input logic out_stall,
	input logic signed [tna_pkg::NORM_BITS-1:0] normal_x,
	input logic signed [tna_pkg::NORM_BITS-1:0] normal_y,
	input logic signed [tna_pkg::NORM_BITS-1:0] normal_z,
	input logic [tna_pkg::AREA_BITS-1:0] area,
	input logic degenerate
);
	import tna_pkg::*;

	// A stalled result stays on the port unchanged.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(normal_x) && $stable(normal_y)
			&& $stable(normal_z) && $stable(area) && $stable(degenerate))
		else $error("stalled result changed");

	// The input is held back only while a result waits at the output.
	a_backpressure: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("input stalled without output stall");

	// A degenerate triangle reports a zero normal and zero area.
	a_degenerate: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && degenerate |-> normal_x == 0 && normal_y == 0 && normal_z == 0
			&& area == 0)
		else $error("degenerate result not zero");

	// A proper triangle has at least one nonzero normal component.
	a_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !degenerate |-> !(normal_x == 0 && normal_y == 0 && normal_z == 0))
		else $error("normal of proper triangle is zero");

endmodule

bind triangle_normal_and_area_top tna_checker u_tna_checker (.*);
